### design/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned UnitWidth  = 16;
	localparam int unsigned CountWidth = 16;
	localparam int unsigned NeedWidth  = 2;

	localparam logic [UnitWidth-1:0]  ReplacementUnit = UnitWidth'(63);
	localparam logic [CountWidth-1:0] CountMax        = '1;

	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_CONT,
		CLS_INVALID
	} byte_class_t;

	typedef struct packed {
		logic                  in_seq;
		logic [UnitWidth-1:0]  acc;
		logic [NeedWidth-1:0]  need;
		logic [CountWidth-1:0] count;
		logic                  limit_hit;
	} dec_state_t;

	typedef struct packed {
		logic [UnitWidth-1:0]  code_unit;
		logic                  is_end;
		logic [CountWidth-1:0] unit_count;
	} dec_result_t;

	function automatic byte_class_t classify(input logic [ByteWidth-1:0] b);
		byte_class_t cls;
		if (b == '0) begin
			cls = CLS_ZERO;
		end else if (b[7] == 1'b0) begin
			cls = CLS_ASCII;
		end else if (b[7:6] == 2'b10) begin
			cls = CLS_CONT;
		end else if (b[7:5] == 3'b110) begin
			cls = CLS_LEAD2;
		end else if (b[7:4] == 4'b1110) begin
			cls = CLS_LEAD3;
		end else if (b[7:3] == 5'b11110) begin
			cls = CLS_LEAD4;
		end else begin
			cls = CLS_INVALID;
		end
		return cls;
	endfunction

endpackage

### design/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code unit decoder with '?' replacement and a per-string
// unit limit.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle and returns any result in the cycle after
// the transfer: the byte is classified and the sequence state advanced by
// shallow logic feeding a single result register, so a new byte is accepted
// in every cycle in which the result register is empty or being drained.
// Code units are the low 16 bits of the decoded code point; a zero byte
// yields an end result with the unit count and clears the string state.
module utf8_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_limit_we,
	input  logic [15:0] unit_limit_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        is_end,
	output logic [15:0] unit_count
);

	logic [utf8sd_pkg::CountWidth-1:0] unit_limit_q;
	utf8sd_pkg::dec_state_t            state_q;
	utf8sd_pkg::dec_state_t            state_nxt;
	utf8sd_pkg::dec_result_t           res;
	utf8sd_pkg::dec_result_t           res_s1;
	logic                              emit;
	logic                              valid_s1;
	logic                              accept;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	utf8sd_decode u_decode (
		.in_byte    (in_byte),
		.unit_limit (unit_limit_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.emit       (emit),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_limit_q <= '0;
			state_q      <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (unit_limit_we) begin
				unit_limit_q <= unit_limit_wdata;
			end
			if (accept) begin
				state_q  <= state_nxt;
				valid_s1 <= emit;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_s1 <= res;
		end
	end

	assign out_valid  = valid_s1;
	assign code_unit  = res_s1.code_unit;
	assign is_end     = res_s1.is_end;
	assign unit_count = res_s1.unit_count;

	a_end_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> code_unit == '0)
		else $error("End result carries a nonzero code unit.");

	a_unit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> unit_count != '0)
		else $error("Code unit result carries a zero unit count.");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_byte == '0 |=> state_q.count == '0 && !state_q.in_seq
			&& !state_q.limit_hit)
		else $error("String state not cleared after a terminating transfer.");

	a_idle_no_need: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.in_seq |-> state_q.need == '0)
		else $error("Continuation count pending while no sequence is open.");

endmodule

### design/utf8sd_decode.sv
// ----------------------------------------------------------------------------
// utf8sd_decode
// Per-byte next-state and result logic: classifies one byte, advances the
// sequence accumulator and the unit count, and decides whether a result forms.
// ----------------------------------------------------------------------------
module utf8sd_decode (
	input  logic [utf8sd_pkg::ByteWidth-1:0]  in_byte,
	input  logic [utf8sd_pkg::CountWidth-1:0] unit_limit,
	input  utf8sd_pkg::dec_state_t            cur,
	output utf8sd_pkg::dec_state_t            nxt,
	output logic                              emit,
	output utf8sd_pkg::dec_result_t           res
);

	utf8sd_pkg::byte_class_t               cls;
	logic [utf8sd_pkg::CountWidth-1:0]     count_inc;
	logic [utf8sd_pkg::UnitWidth-1:0]      acc_shift;
	logic                                  at_limit;

	assign cls       = utf8sd_pkg::classify(in_byte);
	assign count_inc = (cur.count == utf8sd_pkg::CountMax) ? cur.count
	                   : cur.count + 1'b1;
	assign acc_shift = {cur.acc[utf8sd_pkg::UnitWidth-7:0], in_byte[5:0]};
	assign at_limit  = cur.limit_hit || ((unit_limit != '0) && (cur.count >= unit_limit));

	always_comb begin
		nxt            = cur;
		emit           = 1'b0;
		res.code_unit  = utf8sd_pkg::ReplacementUnit;
		res.is_end     = 1'b0;
		res.unit_count = count_inc;
		if (cls == utf8sd_pkg::CLS_ZERO) begin
			emit           = 1'b1;
			res.code_unit  = '0;
			res.is_end     = 1'b1;
			res.unit_count = cur.count;
			nxt            = '0;
		end else if (at_limit) begin
			nxt.limit_hit = 1'b1;
		end else begin
			unique case (cls)
				utf8sd_pkg::CLS_ASCII: begin
					emit      = 1'b1;
					nxt.count = count_inc;
					if (cur.in_seq) begin
						nxt.in_seq = 1'b0;
						nxt.acc    = '0;
						nxt.need   = '0;
					end else begin
						res.code_unit = utf8sd_pkg::UnitWidth'(in_byte);
					end
				end
				utf8sd_pkg::CLS_LEAD2, utf8sd_pkg::CLS_LEAD3, utf8sd_pkg::CLS_LEAD4: begin
					if (cur.in_seq) begin
						emit       = 1'b1;
						nxt.count  = count_inc;
						nxt.in_seq = 1'b0;
						nxt.acc    = '0;
						nxt.need   = '0;
					end else begin
						nxt.in_seq = 1'b1;
						if (cls == utf8sd_pkg::CLS_LEAD2) begin
							nxt.acc  = utf8sd_pkg::UnitWidth'(in_byte[4:0]);
							nxt.need = 2'd1;
						end else if (cls == utf8sd_pkg::CLS_LEAD3) begin
							nxt.acc  = utf8sd_pkg::UnitWidth'(in_byte[3:0]);
							nxt.need = 2'd2;
						end else begin
							nxt.acc  = utf8sd_pkg::UnitWidth'(in_byte[2:0]);
							nxt.need = 2'd3;
						end
					end
				end
				utf8sd_pkg::CLS_CONT: begin
					if (cur.in_seq) begin
						if (cur.need == 2'd1) begin
							emit          = 1'b1;
							res.code_unit = acc_shift;
							nxt.count     = count_inc;
							nxt.in_seq    = 1'b0;
							nxt.acc       = '0;
							nxt.need      = '0;
						end else begin
							nxt.acc  = acc_shift;
							nxt.need = cur.need - 1'b1;
						end
					end
				end
				utf8sd_pkg::CLS_INVALID: begin
					emit       = 1'b1;
					nxt.count  = count_inc;
					nxt.in_seq = 1'b0;
					nxt.acc    = '0;
					nxt.need   = '0;
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives byte strings into the decoder under several unit limits, with random
// gaps on both channels and a long output stall, and checks every result
// against a cycle-free prediction of the decoder state.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IdleLimit       = 5000;
	localparam int unsigned LongHold        = 300;
	localparam int unsigned PhaseItems      = 200;
	localparam int unsigned PhaseCount      = 10;
	localparam int unsigned DrainCycles     = 4;
	localparam int unsigned ReportLimit     = 100;

	class utf8_scoreboard;
		utf8sd_pkg::dec_result_t             expected_q[$];
		bit                                  in_seq;
		bit [20:0]                           acc;
		bit [1:0]                            need;
		bit [utf8sd_pkg::CountWidth-1:0]     count;
		bit                                  stopped;
		bit [15:0]                           unit_limit;
		int unsigned                         errors;

		function new();
			unit_limit = '0;
			errors     = 0;
			clear_string();
		endfunction

		function void close_seq();
			in_seq = 1'b0;
			acc    = '0;
			need   = '0;
		endfunction

		function void clear_string();
			close_seq();
			count   = '0;
			stopped = 1'b0;
		endfunction

		function void push_unit(input bit [20:0] unit);
			utf8sd_pkg::dec_result_t r;
			if (count != utf8sd_pkg::CountMax) begin
				count++;
			end
			r.code_unit  = unit[utf8sd_pkg::UnitWidth-1:0];
			r.is_end     = 1'b0;
			r.unit_count = count;
			expected_q.push_back(r);
		endfunction

		function void note_byte(input bit [7:0] b);
			utf8sd_pkg::dec_result_t r;
			bit [20:0]               unit;
			if (b == 8'h00) begin
				r.code_unit  = '0;
				r.is_end     = 1'b1;
				r.unit_count = count;
				expected_q.push_back(r);
				clear_string();
				return;
			end
			if (stopped || (unit_limit != 0 && count >= unit_limit)) begin
				stopped = 1'b1;
				return;
			end
			casez (b)
				8'b0???????: begin
					if (in_seq) begin
						close_seq();
						push_unit(21'(utf8sd_pkg::ReplacementUnit));
					end else begin
						push_unit(21'(b));
					end
				end
				8'b10??????: begin
					if (in_seq) begin
						acc  = {acc[14:0], b[5:0]};
						need = need - 2'd1;
						if (need == 0) begin
							unit = acc;
							close_seq();
							push_unit(unit);
						end
					end
				end
				8'b110?????, 8'b1110????, 8'b11110???: begin
					if (in_seq) begin
						close_seq();
						push_unit(21'(utf8sd_pkg::ReplacementUnit));
					end else begin
						in_seq = 1'b1;
						if (b[7:5] == 3'b110) begin
							acc  = 21'(b[4:0]);
							need = 2'd1;
						end else if (b[7:4] == 4'b1110) begin
							acc  = 21'(b[3:0]);
							need = 2'd2;
						end else begin
							acc  = 21'(b[2:0]);
							need = 2'd3;
						end
					end
				end
				default: begin
					close_seq();
					push_unit(21'(utf8sd_pkg::ReplacementUnit));
				end
			endcase
		endfunction

		function void report(input string field, input int unsigned exp_v,
				input int unsigned act_v);
			errors++;
			if (errors <= ReportLimit) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, exp_v, act_v);
			end
		endfunction

		function void check_result(input logic [15:0] code, input logic fin,
				input logic [15:0] cnt);
			utf8sd_pkg::dec_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= ReportLimit) begin
					$display("%0t: unexpected result, code_unit %0d is_end %0d unit_count %0d",
						$time, code, fin, cnt);
				end
				return;
			end
			e = expected_q.pop_front();
			if (code !== e.code_unit) begin
				report("code_unit", e.code_unit, code);
			end
			if (fin !== e.is_end) begin
				report("is_end", e.is_end, fin);
			end
			if (cnt !== e.unit_count) begin
				report("unit_count", e.unit_count, cnt);
			end
		endfunction
	endclass

	logic        clk              = 1'b0;
	logic        arst_n           = 1'b0;
	logic        unit_limit_we    = 1'b0;
	logic [15:0] unit_limit_wdata = '0;
	logic        in_valid         = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte          = '0;
	logic        out_valid;
	logic        out_ready        = 1'b0;
	logic [15:0] code_unit;
	logic        is_end;
	logic [15:0] unit_count;

	utf8_scoreboard decode_sb = new();
	bit             no_idle   = 1'b0;
	bit             long_hold = 1'b0;
	int unsigned    bytes_sent = 0;
	int unsigned    quiet_cycles = 0;
	int unsigned    rx_gap;

	utf8_stream_decoder_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.unit_limit_we    (unit_limit_we),
		.unit_limit_wdata (unit_limit_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.code_unit        (code_unit),
		.is_end           (is_end),
		.unit_count       (unit_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			decode_sb.check_result(code_unit, is_end, unit_count);
		end
		if (in_valid && in_ready) begin
			decode_sb.note_byte(in_byte);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	always begin
		if (long_hold) begin
			rx_gap    = LongHold;
			long_hold = 1'b0;
		end else begin
			rx_gap = no_idle ? 0 : $urandom_range(0, 16);
		end
		if (rx_gap > 0) begin
			out_ready <= 1'b0;
			repeat (rx_gap) @(posedge clk);
		end
		out_ready <= 1'b1;
		do @(posedge clk); while (!out_valid);
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_char(input int unsigned len, input int unsigned conts);
		case (len)
			1: send_byte({1'b0, 7'($urandom_range(1, 127))});
			2: send_byte({3'b110, 5'($urandom)});
			3: send_byte({4'b1110, 4'($urandom)});
			default: send_byte({5'b11110, 3'($urandom)});
		endcase
		repeat (conts) send_byte({2'b10, 6'($urandom)});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (decode_sb.expected_q.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		unit_limit_we    <= 1'b1;
		unit_limit_wdata <= value;
		@(posedge clk);
		unit_limit_we <= 1'b0;
		decode_sb.unit_limit = value;
	endtask

	task automatic send_random(input int unsigned n_items);
		int unsigned first;
		int unsigned chars;
		int unsigned kind;
		int unsigned len;
		first = bytes_sent;
		while (bytes_sent - first < n_items) begin
			chars = $urandom_range(0, 12);
			repeat (chars) begin
				kind = $urandom_range(0, 99);
				if (kind < 72) begin
					len = $urandom_range(1, 4);
					send_char(len, len - 1);
				end else if (kind < 82) begin
					len = $urandom_range(2, 4);
					send_char(len, $urandom_range(0, len - 2));
				end else if (kind < 91) begin
					send_byte({2'b10, 6'($urandom)});
				end else begin
					send_byte({5'b11111, 3'($urandom)});
				end
			end
			send_byte(8'h00);
		end
	endtask

	initial begin
		logic [7:0]  directed_bytes[] = '{
			8'h00, 8'h41, 8'h7f, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
			8'hf0, 8'h9f, 8'h98, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
			8'h80, 8'hff, 8'hf8, 8'hc3, 8'h41, 8'he2, 8'hc3, 8'hc0,
			8'h80, 8'he2, 8'h82, 8'h00
		};
		logic [7:0]  limit_bytes[] = '{8'h41, 8'h42, 8'hc3, 8'ha9, 8'h00, 8'h00};
		logic [15:0] phase_limit;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_limit(16'd0);
		foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
		drain();

		write_limit(16'd1);
		foreach (limit_bytes[k]) send_byte(limit_bytes[k]);
		drain();

		// The limit is lowered below the count of an open string.
		write_limit(16'd0);
		repeat (3) send_byte(8'h41);
		drain();
		write_limit(16'd2);
		send_byte(8'h42);
		send_byte(8'h00);
		drain();

		for (int unsigned p = 0; p < PhaseCount; p++) begin
			case (p)
				1: phase_limit = 16'd3;
				2: phase_limit = 16'hffff;
				3: phase_limit = 16'd1;
				5: phase_limit = 16'($urandom_range(1, 12));
				6: phase_limit = 16'd2;
				8: phase_limit = 16'($urandom_range(1, 8));
				default: phase_limit = 16'd0;
			endcase
			write_limit(phase_limit);
			no_idle = (p == 4 || p == 7);
			if (p == 2) begin
				long_hold = 1'b1;
			end
			send_random(PhaseItems);
			drain();
		end

		repeat (8) @(posedge clk);
		if (decode_sb.errors == 0 && decode_sb.expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
